FILE: design/hsg_pkg.sv
// shared constants, prime table and types of the halton sequence generator
`default_nettype none

package hsg_pkg;

    // field and datapath widths
    localparam int INDEX_W       = 31;  // running sequence index
    localparam int BASE_W        = 9;   // prime base, largest is 281
    localparam int DEN_W         = 40;  // base^digits stays below 2^40
    localparam int FRACTION_BITS = 32;  // result fraction bits
    localparam int DIM_W         = 6;   // dimension number
    localparam int POS_W         = DIM_W + 1;
    localparam int CNT_W         = 5;   // step counter of the engine

    // prime table
    localparam int TABLE_SIZE  = 48;
    localparam int PRIME_COUNT = 48;

    localparam logic [BASE_W-1:0] PRIME_TABLE [TABLE_SIZE] = '{
        9'd41,  9'd43,  9'd47,  9'd53,  9'd59,  9'd61,  9'd67,  9'd71,
        9'd73,  9'd79,  9'd83,  9'd89,  9'd97,  9'd101, 9'd103, 9'd107,
        9'd109, 9'd113, 9'd127, 9'd131, 9'd137, 9'd139, 9'd149, 9'd151,
        9'd157, 9'd163, 9'd167, 9'd173, 9'd179, 9'd181, 9'd191, 9'd193,
        9'd197, 9'd199, 9'd211, 9'd223, 9'd227, 9'd229, 9'd233, 9'd239,
        9'd241, 9'd251, 9'd257, 9'd263, 9'd269, 9'd271, 9'd277, 9'd281
    };

    // last step of a digit division and of the fraction division
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(INDEX_W - 1);
    localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRACTION_BITS - 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PRIME = 2'd1;

    // request to the radical inverse engine
    typedef struct packed {
        logic              start;
        logic [INDEX_W-1:0] index;
        logic [BASE_W-1:0]  base;
    } t_ri_req;

    // response of the radical inverse engine
    typedef struct packed {
        logic                     done;
        logic [FRACTION_BITS-1:0] value;
    } t_ri_rsp;

    // result of the shared compare and subtract unit
    typedef struct packed {
        logic           ge;
        logic [DEN_W:0] diff;
    } t_sub_rsp;

    // prime base at a table position, zero past the table
    function automatic logic [BASE_W-1:0] prime_at(input logic [DIM_W-1:0] idx);
        logic [BASE_W-1:0] base;
        base = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (idx == DIM_W'(i)) begin
                base = PRIME_TABLE[i];
            end
        end
        return base;
    endfunction

endpackage

`default_nettype wire

FILE: design/hsg_req_if.sv
// request channel of the halton sequence generator
`default_nettype none

interface hsg_req_if;
    logic valid;
    logic ready;
    logic final_sample;
    logic restart;

    modport source (output valid, output final_sample, output restart, input ready);
    modport sink (input valid, input final_sample, input restart, output ready);
endinterface

`default_nettype wire

FILE: design/hsg_res_if.sv
// result channel of the halton sequence generator
`default_nettype none

interface hsg_res_if import hsg_pkg::*; ;
    logic                     valid;
    logic                     ready;
    logic [DIM_W-1:0]         dim_index;
    logic [FRACTION_BITS-1:0] value;
    logic                     last;
    logic                     batch_end;
    logic                     error;

    modport source (output valid, output dim_index, output value, output last,
                    output batch_end, output error, input ready);
    modport sink (input valid, input dim_index, input value, input last,
                  input batch_end, input error, output ready);
endinterface

`default_nettype wire

FILE: design/halton_sequence_generator.sv
// halton sequence generator top level: dimension sequencer and result register
//
//  channel   dir  handshake          payload
//  i_req     in   valid / ready      final_sample, restart
//  o_res     out  valid / ready      dim_index, value, last, batch_end, error
//  i_cfg     in   i_cfg_we           i_cfg_index, i_cfg_data
//
// one result per dimension; it needs one digit division for each of the k
// base-b digits of the sequence index (k <= 6) and then the fraction division,
// all on the single compare and subtract unit doing one division bit a cycle;
// the first result of a point also includes taking the request in S_IDLE
// index zero skips the divisions, a dimension past the table skips the engine
// reset is synchronous, active low; no clearing pass
// i_req.ready is high only between sample points; the result register lets the
// next request be taken while the last result of a point still waits
`default_nettype none

module halton_sequence_generator import hsg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hsg_req_if.sink                    i_req,
    hsg_res_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state                   r_state;
    logic [DIM_W-1:0]         r_num_dims;
    logic [DIM_W-1:0]         r_first_prime;
    logic [INDEX_W-1:0]       r_seq;
    logic [DIM_W-1:0]         r_dims;
    logic [DIM_W-1:0]         r_dim;
    logic                     r_final;
    logic [FRACTION_BITS-1:0] r_pend_value;
    logic                     r_pend_err;

    logic                     r_out_valid;
    logic [DIM_W-1:0]         r_out_dim;
    logic [FRACTION_BITS-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_batch_end;
    logic                     r_out_err;

    logic [DIM_W-1:0]         w_dims_clamped;
    logic [POS_W-1:0]         w_pos;
    logic                     w_err;
    logic                     w_last;
    logic                     w_slot_free;
    logic                     w_emit;
    t_ri_req                  w_ri_req;
    t_ri_rsp                  w_ri_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims    <= DIM_W'(1);
            r_first_prime <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUM_DIMS:    r_num_dims    <= i_cfg_data;
                REG_FIRST_PRIME: r_first_prime <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimension count limited to one..table size
    always_comb begin
        if (r_num_dims == '0) begin
            w_dims_clamped = DIM_W'(1);
        end else if (r_num_dims > DIM_W'(TABLE_SIZE)) begin
            w_dims_clamped = DIM_W'(TABLE_SIZE);
        end else begin
            w_dims_clamped = r_num_dims;
        end
    end

    // base position of the current dimension
    assign w_pos       = {1'b0, r_first_prime} + {1'b0, r_dim};
    assign w_err       = (w_pos >= POS_W'(PRIME_COUNT));
    assign w_last      = (r_dim == r_dims - DIM_W'(1));
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_emit      = (r_state == S_EMIT) && w_slot_free;

    // engine request
    always_comb begin
        w_ri_req.start = (r_state == S_RUN) && !w_err;
        w_ri_req.index = r_seq;
        w_ri_req.base  = prime_at(w_pos[DIM_W-1:0]);
    end

    hsg_radinv u_radinv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ri_req),
        .o_rsp   (w_ri_rsp)
    );

    // dimension sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register fills on emit, empties when taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_dims  <= w_dims_clamped;
                        r_dim   <= '0;
                        r_final <= i_req.final_sample;
                        if (i_req.restart) begin
                            r_seq <= '0;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_err) begin
                        r_pend_value <= '0;
                        r_pend_err   <= 1'b1;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_ri_rsp.done) begin
                        r_pend_value <= w_ri_rsp.value;
                        r_pend_err   <= 1'b0;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_dim       <= r_dim;
                        r_out_value     <= r_pend_value;
                        r_out_last      <= w_last;
                        r_out_batch_end <= w_last && r_final;
                        r_out_err       <= r_pend_err;
                        r_seq           <= r_seq + 1'b1;
                        r_dim           <= r_dim + 1'b1;
                        r_state         <= w_last ? S_IDLE : S_RUN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.dim_index = r_out_dim;
    assign o_res.value     = r_out_value;
    assign o_res.last      = r_out_last;
    assign o_res.batch_end = r_out_batch_end;
    assign o_res.error     = r_out_err;

endmodule

`default_nettype wire

FILE: design/hsg_sub_unit.sv
// shared compare and subtract unit, one restoring division step
`default_nettype none

module hsg_sub_unit import hsg_pkg::*; (
    input  wire logic [DEN_W:0]   i_a,
    input  wire logic [DEN_W-1:0] i_d,
    output t_sub_rsp              o_rsp
);

    // partial remainder against divisor
    always_comb begin
        o_rsp.ge   = (i_a >= {1'b0, i_d});
        o_rsp.diff = i_a - {1'b0, i_d};
    end

endmodule

`default_nettype wire

FILE: design/hsg_radinv.sv
// radical inverse engine: digit divisions and fraction division on one unit
`default_nettype none

module hsg_radinv import hsg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_ri_req   i_req,
    output t_ri_rsp   o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ACC,
        S_FRAC,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [BASE_W-1:0]        r_base;
    logic [INDEX_W-1:0]       r_nq;
    logic [DEN_W-1:0]         r_rem;
    logic [DEN_W-1:0]         r_rev;
    logic [DEN_W-1:0]         r_den;
    logic [FRACTION_BITS-1:0] r_q;

    logic [DEN_W:0]           w_a;
    logic [DEN_W-1:0]         w_d;
    t_sub_rsp                 w_sub;
    logic [DEN_W-1:0]         w_rem_new;
    logic [DEN_W+BASE_W-1:0]  w_rev_prod;
    logic [DEN_W+BASE_W-1:0]  w_den_prod;

    // operand select: digit step divides by the base, fraction step by base^k
    always_comb begin
        if (r_state == S_DIV) begin
            w_a = {{(DEN_W-BASE_W){1'b0}}, r_rem[BASE_W-1:0], r_nq[INDEX_W-1]};
            w_d = {{(DEN_W-BASE_W){1'b0}}, r_base};
        end else begin
            w_a = {r_rem, 1'b0};
            w_d = r_den;
        end
    end

    hsg_sub_unit u_sub (
        .i_a   (w_a),
        .i_d   (w_d),
        .o_rsp (w_sub)
    );

    assign w_rem_new = w_sub.ge ? w_sub.diff[DEN_W-1:0] : w_a[DEN_W-1:0];

    // append the new digit to the reversed number and scale the denominator
    assign w_rev_prod = {{BASE_W{1'b0}}, r_rev} * {{DEN_W{1'b0}}, r_base}
                      + {{DEN_W{1'b0}}, r_rem[BASE_W-1:0]};
    assign w_den_prod = {{BASE_W{1'b0}}, r_den} * {{DEN_W{1'b0}}, r_base};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_base <= i_req.base;
                        r_nq   <= i_req.index;
                        r_rem  <= '0;
                        r_rev  <= '0;
                        r_den  <= DEN_W'(1);
                        r_q    <= '0;
                        r_cnt  <= '0;
                        // index zero has no digits and maps to zero
                        r_state <= (i_req.index == '0) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_new;
                    r_nq  <= {r_nq[INDEX_W-2:0], w_sub.ge};
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ACC: begin
                    r_rev <= w_rev_prod[DEN_W-1:0];
                    r_den <= w_den_prod[DEN_W-1:0];
                    r_cnt <= '0;
                    if (r_nq == '0) begin
                        r_rem   <= w_rev_prod[DEN_W-1:0];
                        r_state <= S_FRAC;
                    end else begin
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_FRAC: begin
                    r_rem <= w_rem_new;
                    r_q   <= {r_q[FRACTION_BITS-2:0], w_sub.ge};
                    if (r_cnt == FRAC_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // response
    always_comb begin
        o_rsp.done  = (r_state == S_DONE);
        o_rsp.value = r_q;
    end

endmodule

`default_nettype wire

FILE: design/hsg_checker.sv
// port-level checks of the halton sequence generator and their binding
`default_nettype none

module hsg_checker import hsg_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_req_valid,
    input wire logic                     i_req_ready,
    input wire logic                     i_res_valid,
    input wire logic                     i_res_ready,
    input wire logic [DIM_W-1:0]         i_res_dim_index,
    input wire logic [FRACTION_BITS-1:0] i_res_value,
    input wire logic                     i_res_last,
    input wire logic                     i_res_batch_end,
    input wire logic                     i_res_error
);

    // a stalled result item holds its value, dimension index and last flag
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_value)
            && $stable(i_res_dim_index) && $stable(i_res_last))
        else $error("result item changed while stalled");

    // batch end only on the last result of a point
    a_batch_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_batch_end |-> i_res_last)
        else $error("batch_end without last");

    // an error result carries a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_error |-> i_res_value == '0)
        else $error("error result with nonzero value");

    // one sample point at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while a point is in progress");

endmodule

bind halton_sequence_generator hsg_checker u_hsg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_dim_index (o_res.dim_index),
    .i_res_value     (o_res.value),
    .i_res_last      (o_res.last),
    .i_res_batch_end (o_res.batch_end),
    .i_res_error     (o_res.error)
);

`default_nettype wire
